>>> rtl/deblocking_edge_filter_core_assert.svh
`ifndef DEBLOCKING_EDGE_FILTER_CORE_ASSERT_SVH
`define DEBLOCKING_EDGE_FILTER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DBF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dbf_pkg.sv
`timescale 1ns / 1ps

package dbf_pkg;

	// Boundary strength codes
	localparam logic [2:0] BS_NONE   = 3'd0;
	localparam logic [2:0] BS_N1     = 3'd1;
	localparam logic [2:0] BS_N2     = 3'd2;
	localparam logic [2:0] BS_N3     = 3'd3;
	localparam logic [2:0] BS_STRONG = 3'd4;

	// Sample plane codes
	localparam logic MODE_CHROMA = 1'b0;
	localparam logic MODE_LUMA   = 1'b1;

	localparam logic [5:0] IDX_MAX = 6'd51;

	localparam logic [7:0] ALPHA_TAB [52] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd4,   8'd4,   8'd5,   8'd6,
		8'd7,   8'd8,   8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd17,  8'd20,  8'd22,
		8'd25,  8'd28,  8'd32,  8'd36,  8'd40,  8'd45,  8'd50,  8'd56,  8'd63,  8'd71,
		8'd80,  8'd90,  8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182, 8'd203, 8'd226,
		8'd255, 8'd255
	};

	localparam logic [4:0] BETA_TAB [52] = '{
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd2,  5'd2,  5'd2,  5'd3,
		5'd3,  5'd3,  5'd3,  5'd4,  5'd4,  5'd4,  5'd6,  5'd6,  5'd7,  5'd7,
		5'd8,  5'd8,  5'd9,  5'd9,  5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12,
		5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16, 5'd17, 5'd17,
		5'd18, 5'd18
	};

	localparam logic [4:0] TC0_BS1_TAB [52] = '{
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
		5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,
		5'd4,  5'd4,  5'd4,  5'd5,  5'd6,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10,
		5'd11, 5'd13
	};

	localparam logic [4:0] TC0_BS2_TAB [52] = '{
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd0,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
		5'd1,  5'd2,  5'd2,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,  5'd4,  5'd4,
		5'd5,  5'd5,  5'd6,  5'd7,  5'd8,  5'd8,  5'd10, 5'd11, 5'd12, 5'd13,
		5'd15, 5'd17
	};

	localparam logic [4:0] TC0_BS3_TAB [52] = '{
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1,
		5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd2,
		5'd2,  5'd3,  5'd3,  5'd3,  5'd4,  5'd4,  5'd4,  5'd5,  5'd6,  5'd6,
		5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd13, 5'd14, 5'd16, 5'd18, 5'd20,
		5'd23, 5'd25
	};

	// One line of samples across the edge plus its filter controls
	typedef struct packed {
		logic [7:0] p3;
		logic [7:0] p2;
		logic [7:0] p1;
		logic [7:0] p0;
		logic [7:0] q0;
		logic [7:0] q1;
		logic [7:0] q2;
		logic [7:0] q3;
		logic [2:0] strength;
		logic [5:0] index_a;
		logic [5:0] index_b;
		logic       mode;
	} dbf_line_t;

	// Filtered samples and the filter-applied flag
	typedef struct packed {
		logic [7:0] p2;
		logic [7:0] p1;
		logic [7:0] p0;
		logic [7:0] q0;
		logic [7:0] q1;
		logic [7:0] q2;
		logic       edge_filtered;
	} dbf_result_t;

	function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic signed [11:0] ext12(input logic [7:0] v);
		return signed'({4'b0000, v});
	endfunction

	function automatic logic [10:0] u11(input logic [7:0] v);
		return {3'b000, v};
	endfunction

	// Clip a signed value to the range -lim..lim
	function automatic logic signed [11:0] clip_tc(input logic signed [11:0] v,
		input logic [5:0] lim);
		logic signed [11:0] lim_s;
		lim_s = signed'({6'b000000, lim});
		if (v < -lim_s)
			return -lim_s;
		else if (v > lim_s)
			return lim_s;
		else
			return v;
	endfunction

	// Clamp a signed value to 0..255
	function automatic logic [7:0] sat_u8(input logic signed [11:0] v);
		if (v < 12'sd0)
			return 8'd0;
		else if (v > 12'sd255)
			return 8'd255;
		else
			return v[7:0];
	endfunction

	// tc0 lookup for the normal filter strengths
	function automatic logic [4:0] tc0_lookup(input logic [5:0] ia, input logic [2:0] bs);
		case (bs)
			BS_N1:   return TC0_BS1_TAB[ia];
			BS_N2:   return TC0_BS2_TAB[ia];
			BS_N3:   return TC0_BS3_TAB[ia];
			default: return 5'd0;
		endcase
	endfunction

endpackage

>>> rtl/dbf_filter.sv
`timescale 1ns / 1ps

module dbf_filter import dbf_pkg::*; (
	input  dbf_line_t   ln,
	output dbf_result_t res
);

	logic [5:0]         ia;
	logic [5:0]         ib;
	logic [2:0]         bs;
	logic [7:0]         alpha;
	logic [7:0]         beta;
	logic [4:0]         tc0;
	logic [7:0]         d_p0q0;
	logic               edge_ok;
	logic               ap;
	logic               aq;
	logic               strong_en;
	logic [8:0]         avg_sum;
	logic [7:0]         avg;
	logic signed [11:0] tp;
	logic signed [11:0] tq;
	logic [5:0]         tc;
	logic signed [11:0] dd;
	logic signed [11:0] delta;
	logic [10:0]        pq;
	logic [10:0]        s_p0;
	logic [10:0]        s_p1;
	logic [10:0]        s_p2;
	logic [10:0]        s_q0;
	logic [10:0]        s_q1;
	logic [10:0]        s_q2;
	logic [10:0]        t_p0;
	logic [10:0]        t_q0;

	// Saturate indices and strength, look up thresholds
	always_comb begin
		ia     = (ln.index_a > IDX_MAX) ? IDX_MAX : ln.index_a;
		ib     = (ln.index_b > IDX_MAX) ? IDX_MAX : ln.index_b;
		bs     = (ln.strength > BS_STRONG) ? BS_STRONG : ln.strength;
		alpha  = ALPHA_TAB[ia];
		beta   = {3'b000, BETA_TAB[ib]};
		tc0    = tc0_lookup(ia, bs);
		d_p0q0 = absdiff(ln.p0, ln.q0);
	end

	// Edge activity tests and side flags
	assign edge_ok = (bs != BS_NONE) && (d_p0q0 < alpha) &&
		(absdiff(ln.p1, ln.p0) < beta) && (absdiff(ln.q1, ln.q0) < beta);
	assign ap        = absdiff(ln.p2, ln.p0) < beta;
	assign aq        = absdiff(ln.q2, ln.q0) < beta;
	assign strong_en = d_p0q0 < ({2'b00, alpha[7:2]} + 8'd2);

	// Normal filter terms
	always_comb begin
		avg_sum = {1'b0, ln.p0} + {1'b0, ln.q0} + 9'd1;
		avg     = avg_sum[8:1];
		tp      = ext12(ln.p2) + ext12(avg) - (ext12(ln.p1) <<< 1);
		tq      = ext12(ln.q2) + ext12(avg) - (ext12(ln.q1) <<< 1);
		if (ln.mode == MODE_LUMA)
			tc = {1'b0, tc0} + {5'b00000, ap} + {5'b00000, aq};
		else
			tc = {1'b0, tc0} + 6'd1;
		dd    = ((ext12(ln.q0) - ext12(ln.p0)) <<< 2) + ext12(ln.p1) - ext12(ln.q1) + 12'sd4;
		delta = clip_tc(dd >>> 3, tc);
	end

	// Strong filter sums
	always_comb begin
		pq   = u11(ln.p0) + u11(ln.q0);
		s_p0 = u11(ln.q1) + ((u11(ln.p1) + pq) << 1) + u11(ln.p2) + 11'd4;
		s_p1 = pq + u11(ln.p1) + u11(ln.p2) + 11'd2;
		s_p2 = ((u11(ln.p3) + u11(ln.p2)) << 1) + u11(ln.p2) + u11(ln.p1) + pq + 11'd4;
		s_q0 = u11(ln.p1) + ((u11(ln.q1) + pq) << 1) + u11(ln.q2) + 11'd4;
		s_q1 = pq + u11(ln.q1) + u11(ln.q2) + 11'd2;
		s_q2 = ((u11(ln.q3) + u11(ln.q2)) << 1) + u11(ln.q2) + u11(ln.q1) + pq + 11'd4;
		t_p0 = (u11(ln.p1) << 1) + u11(ln.p0) + u11(ln.q1) + 11'd2;
		t_q0 = (u11(ln.q1) << 1) + u11(ln.q0) + u11(ln.p1) + 11'd2;
	end

	// Select the filtered samples
	always_comb begin
		res.p2            = ln.p2;
		res.p1            = ln.p1;
		res.p0            = ln.p0;
		res.q0            = ln.q0;
		res.q1            = ln.q1;
		res.q2            = ln.q2;
		res.edge_filtered = edge_ok;
		if (edge_ok) begin
			if (bs != BS_STRONG) begin
				if (ln.mode == MODE_LUMA) begin
					if (ap)
						res.p1 = sat_u8(ext12(ln.p1) + clip_tc(tp >>> 1, {1'b0, tc0}));
					if (aq)
						res.q1 = sat_u8(ext12(ln.q1) + clip_tc(tq >>> 1, {1'b0, tc0}));
				end
				res.p0 = sat_u8(ext12(ln.p0) + delta);
				res.q0 = sat_u8(ext12(ln.q0) - delta);
			end else if (ln.mode == MODE_CHROMA) begin
				res.p0 = t_p0[9:2];
				res.q0 = t_q0[9:2];
			end else begin
				if (strong_en && aq) begin
					res.q0 = s_q0[10:3];
					res.q1 = s_q1[9:2];
					res.q2 = s_q2[10:3];
				end else begin
					res.q0 = t_q0[9:2];
				end
				if (strong_en && ap) begin
					res.p0 = s_p0[10:3];
					res.p1 = s_p1[9:2];
					res.p2 = s_p2[10:3];
				end else begin
					res.p0 = t_p0[9:2];
				end
			end
		end
	end

endmodule

>>> rtl/deblocking_edge_filter_core.sv
`timescale 1ns / 1ps
// H.264 edge deblocking for one line of eight samples (p3..p0 | q0..q3) per beat.
// The block takes one line every cycle while in_stall is low. An input register feeds
// one combinational filter stage (table lookup, activity tests, normal and strong
// filters, clamping), and a result register holds the outcome until the downstream
// side takes it. An accepted beat moves from the input register into the result
// register, which loads only while it is empty or being taken, and the result register
// drives out_valid. in_stall rises only while both registers are full and out_stall
// is high, so with out_stall low the sustained rate is one line per clock. There is
// no configuration and no state carried from one line to the next.
`include "deblocking_edge_filter_core_assert.svh"

module deblocking_edge_filter_core import dbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] p3_in,
	input  logic [7:0] p2_in,
	input  logic [7:0] p1_in,
	input  logic [7:0] p0_in,
	input  logic [7:0] q0_in,
	input  logic [7:0] q1_in,
	input  logic [7:0] q2_in,
	input  logic [7:0] q3_in,
	input  logic [2:0] strength,
	input  logic [5:0] index_a,
	input  logic [5:0] index_b,
	input  logic       mode,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] p2_out,
	output logic [7:0] p1_out,
	output logic [7:0] p0_out,
	output logic [7:0] q0_out,
	output logic [7:0] q1_out,
	output logic [7:0] q2_out,
	output logic       edge_filtered
);

	logic        v_s1;
	dbf_line_t   ln_s1;
	logic        v_s2;
	dbf_result_t res_s2;
	dbf_result_t res_c;
	logic        adv_s2;
	logic        s1_fire;
	logic        zero_fire;
	logic        pass_fire;
	logic        chroma_fire;
	logic [47:0] line_mid;
	logic [47:0] beat_mid;
	logic [31:0] line_outer;
	logic [31:0] beat_outer;

	// Advance the result register when it is empty or being taken
	assign adv_s2   = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !adv_s2;
	assign s1_fire  = v_s1 && adv_s2;

	// Hold pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				v_s1 <= in_valid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ln_s1.p3       <= p3_in;
			ln_s1.p2       <= p2_in;
			ln_s1.p1       <= p1_in;
			ln_s1.p0       <= p0_in;
			ln_s1.q0       <= q0_in;
			ln_s1.q1       <= q1_in;
			ln_s1.q2       <= q2_in;
			ln_s1.q3       <= q3_in;
			ln_s1.strength <= strength;
			ln_s1.index_a  <= index_a;
			ln_s1.index_b  <= index_b;
			ln_s1.mode     <= mode;
		end
	end

	dbf_filter u_filter (
		.ln  (ln_s1),
		.res (res_c)
	);

	// Capture the filtered line
	always_ff @(posedge clk) begin
		if (s1_fire)
			res_s2 <= res_c;
	end

	assign out_valid     = v_s2;
	assign p2_out        = res_s2.p2;
	assign p1_out        = res_s2.p1;
	assign p0_out        = res_s2.p0;
	assign q0_out        = res_s2.q0;
	assign q1_out        = res_s2.q1;
	assign q2_out        = res_s2.q2;
	assign edge_filtered = res_s2.edge_filtered;

	// Gather sample groups and triggers for the checks
	assign zero_fire   = s1_fire && (ln_s1.strength == BS_NONE);
	assign pass_fire   = s1_fire && !res_c.edge_filtered;
	assign chroma_fire = s1_fire && (ln_s1.mode == MODE_CHROMA);
	assign line_mid    = {ln_s1.p2, ln_s1.p1, ln_s1.p0, ln_s1.q0, ln_s1.q1, ln_s1.q2};
	assign beat_mid    = {p2_out, p1_out, p0_out, q0_out, q1_out, q2_out};
	assign line_outer  = {ln_s1.p2, ln_s1.p1, ln_s1.q1, ln_s1.q2};
	assign beat_outer  = {p2_out, p1_out, q1_out, q2_out};

	`DBF_ASSERT_IMP(a_stall_cause, in_stall, v_s1 && out_valid && out_stall, "stall without full pipe")
	`DBF_ASSERT_NEXT(a_bs_none, zero_fire, !edge_filtered, "strength zero filtered")
	`DBF_ASSERT_NEXT(a_pass, pass_fire, beat_mid == $past(line_mid), "unfiltered line changed")
	`DBF_ASSERT_NEXT(a_chroma, chroma_fire, beat_outer == $past(line_outer), "chroma outer changed")

endmodule
